// File: rtl/stl_pkg.sv
`default_nettype none
package stl_pkg;

	localparam int FRAC_BITS = 16;

	localparam int CW    = 32;              // coordinate width
	localparam int DW    = CW + 1;          // vertex difference width
	localparam int PW    = 2 * DW;          // product of two differences
	localparam int DOTW  = PW + 2;          // dot product of two vectors
	localparam int HW    = DOTW / 2;        // half of a dot product
	localparam int PPW   = 2 * (HW + 1);    // partial product width
	localparam int PRODW = 2 * DOTW;        // product of two dot products
	localparam int VW    = PRODW + 1;       // barycentric cross term
	localparam int DIVW  = VW + 4;          // divider operands
	localparam int TW    = FRAC_BITS + 1;   // ratio in [0, 1]
	localparam int SCW   = DW + TW + 1;     // direction times ratio
	localparam int SHW   = SCW - FRAC_BITS; // after the fraction is dropped
	localparam int NW    = SHW + 1;         // base plus two offsets
	localparam int RW    = 31;              // radius register
	localparam int R2W   = 2 * RW;
	localparam int DISTW = PW + 2;
	localparam int DIV_LAT = FRAC_BITS + 2;

	localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [2:0] {
		REG_A  = 3'd0,
		REG_B  = 3'd1,
		REG_AB = 3'd2,
		REG_C  = 3'd3,
		REG_AC = 3'd4,
		REG_BC = 3'd5,
		REG_IN = 3'd6
	} region_t;

	typedef struct packed {
		logic [2:0][CW-1:0] p;
		logic [2:0][CW-1:0] a;
		logic [2:0][CW-1:0] b;
		logic [2:0][CW-1:0] c;
	} tri_t;

	typedef struct packed {
		tri_t               t;
		logic [2:0][DW-1:0] ab;
		logic [2:0][DW-1:0] ac;
		logic [2:0][DW-1:0] bc;
	} geo_t;

	typedef logic [5:0][DOTW-1:0] dots_t;

	typedef struct packed {
		logic [2:0][CW-1:0] base;
		logic [2:0][CW-1:0] a;
		logic [2:0][CW-1:0] p;
		logic [2:0][DW-1:0] dir_a;
		logic [2:0][DW-1:0] dir_b;
		region_t            region;
	} pick_t;

	function automatic logic [PW-1:0] smul_diff(logic signed [DW-1:0] x,
			logic signed [DW-1:0] y);
		logic signed [PW-1:0] r;
		r = x * y;
		return r;
	endfunction

	function automatic logic [PPW-1:0] smul_part(logic signed [HW:0] x,
			logic signed [HW:0] y);
		logic signed [PPW-1:0] r;
		r = x * y;
		return r;
	endfunction

	function automatic logic [SCW-1:0] smul_scale(logic signed [DW-1:0] x,
			logic signed [TW:0] y);
		logic signed [SCW-1:0] r;
		r = x * y;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/stl_dot.sv
`default_nettype none
// Edge and offset vectors, then the six dot products d1..d6.
module stl_dot (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire stl_pkg::tri_t in_tri,
	output logic               out_valid,
	output stl_pkg::geo_t      geo,
	output stl_pkg::dots_t     dots
);

	logic                                  v_s1, v_s2, v_s3;
	stl_pkg::geo_t                         geo_s1, geo_s2, geo_s3;
	logic [2:0][2:0][stl_pkg::DW-1:0]      off_s1;
	logic [5:0][2:0][stl_pkg::PW-1:0]      prod_s2;
	stl_pkg::dots_t                        dots_s3;

	stl_pkg::geo_t                         geo_c;
	logic [2:0][2:0][stl_pkg::DW-1:0]      off_c;
	logic [5:0][2:0][stl_pkg::PW-1:0]      prod_c;
	stl_pkg::dots_t                        dots_c;

	always_comb begin
		geo_c.t = in_tri;
		for (int i = 0; i < 3; i++) begin
			geo_c.ab[i] = {in_tri.b[i][stl_pkg::CW-1], in_tri.b[i]}
				- {in_tri.a[i][stl_pkg::CW-1], in_tri.a[i]};
			geo_c.ac[i] = {in_tri.c[i][stl_pkg::CW-1], in_tri.c[i]}
				- {in_tri.a[i][stl_pkg::CW-1], in_tri.a[i]};
			geo_c.bc[i] = {in_tri.c[i][stl_pkg::CW-1], in_tri.c[i]}
				- {in_tri.b[i][stl_pkg::CW-1], in_tri.b[i]};
			off_c[0][i] = {in_tri.p[i][stl_pkg::CW-1], in_tri.p[i]}
				- {in_tri.a[i][stl_pkg::CW-1], in_tri.a[i]};
			off_c[1][i] = {in_tri.p[i][stl_pkg::CW-1], in_tri.p[i]}
				- {in_tri.b[i][stl_pkg::CW-1], in_tri.b[i]};
			off_c[2][i] = {in_tri.p[i][stl_pkg::CW-1], in_tri.p[i]}
				- {in_tri.c[i][stl_pkg::CW-1], in_tri.c[i]};
		end
	end

	// Even products use edge ab, odd ones edge ac; pairs step through ap, bp, cp.
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			for (int i = 0; i < 3; i++) begin
				prod_c[k][i] = stl_pkg::smul_diff(
					k[0] ? geo_s1.ac[i] : geo_s1.ab[i], off_s1[k >> 1][i]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			dots_c[k] = {{2{prod_s2[k][0][stl_pkg::PW-1]}}, prod_s2[k][0]}
				+ {{2{prod_s2[k][1][stl_pkg::PW-1]}}, prod_s2[k][1]}
				+ {{2{prod_s2[k][2][stl_pkg::PW-1]}}, prod_s2[k][2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1  <= geo_c;
			off_s1  <= off_c;
			geo_s2  <= geo_s1;
			prod_s2 <= prod_c;
			geo_s3  <= geo_s2;
			dots_s3 <= dots_c;
		end
	end

	assign out_valid = v_s3;
	assign geo       = geo_s3;
	assign dots      = dots_s3;

endmodule
`default_nettype wire

// File: rtl/stl_region.sv
`default_nettype none
// Cross terms va, vb, vc from the dot products, Voronoi region choice and the
// operands of the two ratio dividers.
module stl_region (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire stl_pkg::geo_t                geo,
	input  wire stl_pkg::dots_t               dots,
	output logic                              out_valid,
	output stl_pkg::pick_t                    pick,
	output logic [stl_pkg::DIVW-1:0]          num_a,
	output logic [stl_pkg::DIVW-1:0]          den_a,
	output logic [stl_pkg::DIVW-1:0]          num_b,
	output logic [stl_pkg::DIVW-1:0]          den_b
);

	localparam int DEXT = stl_pkg::DIVW - stl_pkg::DOTW;
	localparam int VEXT = stl_pkg::DIVW - stl_pkg::VW;

	logic                                   v_s4, v_s5, v_s6, v_s7;
	stl_pkg::geo_t                          geo_s4, geo_s5, geo_s6;
	stl_pkg::dots_t                         dots_s4, dots_s5, dots_s6;
	logic [5:0][3:0][stl_pkg::PPW-1:0]      part_s4;
	logic [5:0][stl_pkg::PRODW-1:0]         prod_s5;
	logic [2:0][stl_pkg::VW-1:0]            vv_s6;
	logic [stl_pkg::DOTW:0]                 e43_s6, e56_s6;
	stl_pkg::pick_t                         pick_s7;
	logic [stl_pkg::DIVW-1:0]               num_a_s7, den_a_s7, num_b_s7, den_b_s7;

	logic [5:0][stl_pkg::DOTW-1:0]          mx, my;
	logic [5:0][3:0][stl_pkg::PPW-1:0]      part_c;
	logic [5:0][stl_pkg::PRODW-1:0]         prod_c;
	logic [5:0][stl_pkg::PPW-1:0]           mid;
	logic [2:0][stl_pkg::VW-1:0]            vv_c;
	logic [stl_pkg::DOTW:0]                 e43_c, e56_c;
	logic [5:0][stl_pkg::DIVW-1:0]          dx;
	logic [stl_pkg::DIVW-1:0]               vax, vbx, vcx, e43x, e56x, den_all;
	logic [6:0]                             sel;
	stl_pkg::pick_t                         pick_c;
	logic [stl_pkg::DIVW-1:0]               num_a_c, den_a_c, num_b_c, den_b_c;

	function automatic logic le0(logic [stl_pkg::DIVW-1:0] x);
		return x[stl_pkg::DIVW-1] || (x == '0);
	endfunction

	// Products: 0 d1*d4, 1 d3*d2, 2 d5*d2, 3 d1*d6, 4 d3*d6, 5 d5*d4.
	always_comb begin
		mx[0] = dots[0]; my[0] = dots[3];
		mx[1] = dots[2]; my[1] = dots[1];
		mx[2] = dots[4]; my[2] = dots[1];
		mx[3] = dots[0]; my[3] = dots[5];
		mx[4] = dots[2]; my[4] = dots[5];
		mx[5] = dots[4]; my[5] = dots[3];
		for (int m = 0; m < 6; m++) begin
			part_c[m][0] = stl_pkg::smul_part(
				{mx[m][stl_pkg::DOTW-1], mx[m][stl_pkg::DOTW-1:stl_pkg::HW]},
				{my[m][stl_pkg::DOTW-1], my[m][stl_pkg::DOTW-1:stl_pkg::HW]});
			part_c[m][1] = stl_pkg::smul_part(
				{mx[m][stl_pkg::DOTW-1], mx[m][stl_pkg::DOTW-1:stl_pkg::HW]},
				{1'b0, my[m][stl_pkg::HW-1:0]});
			part_c[m][2] = stl_pkg::smul_part({1'b0, mx[m][stl_pkg::HW-1:0]},
				{my[m][stl_pkg::DOTW-1], my[m][stl_pkg::DOTW-1:stl_pkg::HW]});
			part_c[m][3] = stl_pkg::smul_part({1'b0, mx[m][stl_pkg::HW-1:0]},
				{1'b0, my[m][stl_pkg::HW-1:0]});
		end
	end

	always_comb begin
		for (int m = 0; m < 6; m++) begin
			mid[m] = part_s4[m][1] + part_s4[m][2];
			prod_c[m] = {part_s4[m][0][stl_pkg::DOTW-1:0], {stl_pkg::DOTW{1'b0}}}
				+ {{(stl_pkg::PRODW - stl_pkg::PPW - stl_pkg::HW){mid[m][stl_pkg::PPW-1]}},
					mid[m], {stl_pkg::HW{1'b0}}}
				+ {{(stl_pkg::PRODW - stl_pkg::PPW){1'b0}}, part_s4[m][3]};
		end
	end

	// vv index 0 va, 1 vb, 2 vc.
	always_comb begin
		vv_c[0] = {prod_s5[4][stl_pkg::PRODW-1], prod_s5[4]}
			- {prod_s5[5][stl_pkg::PRODW-1], prod_s5[5]};
		vv_c[1] = {prod_s5[2][stl_pkg::PRODW-1], prod_s5[2]}
			- {prod_s5[3][stl_pkg::PRODW-1], prod_s5[3]};
		vv_c[2] = {prod_s5[0][stl_pkg::PRODW-1], prod_s5[0]}
			- {prod_s5[1][stl_pkg::PRODW-1], prod_s5[1]};
		e43_c = {dots_s5[3][stl_pkg::DOTW-1], dots_s5[3]}
			- {dots_s5[2][stl_pkg::DOTW-1], dots_s5[2]};
		e56_c = {dots_s5[4][stl_pkg::DOTW-1], dots_s5[4]}
			- {dots_s5[5][stl_pkg::DOTW-1], dots_s5[5]};
	end

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			dx[k] = {{DEXT{dots_s6[k][stl_pkg::DOTW-1]}}, dots_s6[k]};
		end
		vax  = {{VEXT{vv_s6[0][stl_pkg::VW-1]}}, vv_s6[0]};
		vbx  = {{VEXT{vv_s6[1][stl_pkg::VW-1]}}, vv_s6[1]};
		vcx  = {{VEXT{vv_s6[2][stl_pkg::VW-1]}}, vv_s6[2]};
		e43x = {{(DEXT-1){e43_s6[stl_pkg::DOTW]}}, e43_s6};
		e56x = {{(DEXT-1){e56_s6[stl_pkg::DOTW]}}, e56_s6};
		den_all = vax + vbx + vcx;

		// Regions are tested in priority order; the first match wins.
		sel = '0;
		if (le0(dx[0]) && le0(dx[1])) begin
			sel[0] = 1'b1;
		end else if (!dx[2][stl_pkg::DIVW-1] && ($signed(dx[3]) <= $signed(dx[2]))) begin
			sel[1] = 1'b1;
		end else if (le0(vcx) && !dx[0][stl_pkg::DIVW-1] && le0(dx[2])) begin
			sel[2] = 1'b1;
		end else if (!dx[5][stl_pkg::DIVW-1] && ($signed(dx[4]) <= $signed(dx[5]))) begin
			sel[3] = 1'b1;
		end else if (le0(vbx) && !dx[1][stl_pkg::DIVW-1] && le0(dx[5])) begin
			sel[4] = 1'b1;
		end else if (le0(vax) && !e43x[stl_pkg::DIVW-1] && !e56x[stl_pkg::DIVW-1]) begin
			sel[5] = 1'b1;
		end else begin
			sel[6] = 1'b1;
		end

		pick_c.a      = geo_s6.t.a;
		pick_c.p      = geo_s6.t.p;
		pick_c.base   = geo_s6.t.a;
		pick_c.dir_a  = '0;
		pick_c.dir_b  = '0;
		pick_c.region = stl_pkg::REG_A;
		// Regions without a ratio feed 0 / 1 so that neither divider flags them.
		num_a_c = '0;
		den_a_c = {{(stl_pkg::DIVW-1){1'b0}}, 1'b1};
		num_b_c = '0;
		den_b_c = {{(stl_pkg::DIVW-1){1'b0}}, 1'b1};
		if (sel[1]) begin
			pick_c.base   = geo_s6.t.b;
			pick_c.region = stl_pkg::REG_B;
		end
		if (sel[2]) begin
			pick_c.dir_a  = geo_s6.ab;
			pick_c.region = stl_pkg::REG_AB;
			num_a_c       = dx[0];
			den_a_c       = dx[0] - dx[2];
		end
		if (sel[3]) begin
			pick_c.base   = geo_s6.t.c;
			pick_c.region = stl_pkg::REG_C;
		end
		if (sel[4]) begin
			pick_c.dir_a  = geo_s6.ac;
			pick_c.region = stl_pkg::REG_AC;
			num_a_c       = dx[1];
			den_a_c       = dx[1] - dx[5];
		end
		if (sel[5]) begin
			pick_c.base   = geo_s6.t.b;
			pick_c.dir_a  = geo_s6.bc;
			pick_c.region = stl_pkg::REG_BC;
			num_a_c       = e43x;
			den_a_c       = e43x + e56x;
		end
		if (sel[6]) begin
			pick_c.dir_a  = geo_s6.ab;
			pick_c.dir_b  = geo_s6.ac;
			pick_c.region = stl_pkg::REG_IN;
			num_a_c       = vbx;
			den_a_c       = den_all;
			num_b_c       = vcx;
			den_b_c       = den_all;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s4   <= geo;
			dots_s4  <= dots;
			part_s4  <= part_c;
			geo_s5   <= geo_s4;
			dots_s5  <= dots_s4;
			prod_s5  <= prod_c;
			geo_s6   <= geo_s5;
			dots_s6  <= dots_s5;
			vv_s6    <= vv_c;
			e43_s6   <= e43_c;
			e56_s6   <= e56_c;
			pick_s7  <= pick_c;
			num_a_s7 <= num_a_c;
			den_a_s7 <= den_a_c;
			num_b_s7 <= num_b_c;
			den_b_s7 <= den_b_c;
		end
	end

	assign out_valid = v_s7;
	assign pick      = pick_s7;
	assign num_a     = num_a_s7;
	assign den_a     = den_a_s7;
	assign num_b     = num_b_s7;
	assign den_b     = den_b_s7;

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> $onehot(sel))
		else $error("region priority picked other than exactly one region");

	a_plain_operands: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && (pick_s7.region == stl_pkg::REG_B || pick_s7.region == stl_pkg::REG_C)
		|-> num_a_s7 == '0 && den_a_s7 == {{(stl_pkg::DIVW-1){1'b0}}, 1'b1})
		else $error("vertex region carries a divider operand");

endmodule
`default_nettype wire

// File: rtl/stl_div.sv
`default_nettype none
// Ratio num/den clamped to [0, 1] with FRAC_BITS fraction bits: a sign stage,
// a range stage, then one restoring quotient bit per stage. A zero divisor
// comes out as deg.
module stl_div (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [stl_pkg::DIVW-1:0]  num,
	input  wire logic [stl_pkg::DIVW-1:0]  den,
	output logic [stl_pkg::TW-1:0]         t,
	output logic                           deg
);

	localparam int N = stl_pkg::FRAC_BITS;

	logic [stl_pkg::DIVW-1:0] mn_s0, md_s0;
	logic                     tz_s0, deg_s0;
	logic [stl_pkg::DIVW-1:0] rem_s [N+1];
	logic [stl_pkg::DIVW-1:0] dv_s  [N+1];
	logic [stl_pkg::TW-1:0]   q_s   [N+1];
	logic                     done_s[N+1];
	logic                     deg_s [N+1];

	logic                     neg;
	logic                     ge0;
	logic [stl_pkg::DIVW-1:0] sh   [N];
	logic                     ge   [N];

	assign neg = num[stl_pkg::DIVW-1];
	assign ge0 = mn_s0 >= md_s0;

	always_comb begin
		for (int k = 0; k < N; k++) begin
			sh[k] = {rem_s[k][stl_pkg::DIVW-2:0], 1'b0};
			ge[k] = sh[k] >= dv_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s0  <= neg ? ('0 - num) : num;
			md_s0  <= neg ? ('0 - den) : den;
			tz_s0  <= (num == '0) || (num[stl_pkg::DIVW-1] != den[stl_pkg::DIVW-1]);
			deg_s0 <= den == '0;

			rem_s[0]  <= mn_s0;
			dv_s[0]   <= md_s0;
			q_s[0]    <= tz_s0 ? '0 : (ge0 ? stl_pkg::ONE : '0);
			done_s[0] <= tz_s0 || ge0;
			deg_s[0]  <= deg_s0;

			for (int k = 0; k < N; k++) begin
				rem_s[k+1]  <= ge[k] ? (sh[k] - dv_s[k]) : sh[k];
				dv_s[k+1]   <= dv_s[k];
				q_s[k+1]    <= done_s[k] ? q_s[k] : {q_s[k][stl_pkg::TW-2:0], ge[k]};
				done_s[k+1] <= done_s[k];
				deg_s[k+1]  <= deg_s[k];
			end
		end
	end

	assign t   = q_s[N];
	assign deg = deg_s[N];

endmodule
`default_nettype wire

// File: rtl/stl_out.sv
`default_nettype none
// Interpolation of the closest point, saturation, squared distance and the
// radius test.
module stl_out (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire stl_pkg::pick_t            pick,
	input  wire logic [stl_pkg::TW-1:0]    t,
	input  wire logic [stl_pkg::TW-1:0]    w,
	input  wire logic                      deg,
	input  wire logic [stl_pkg::R2W-1:0]   r2,
	output logic                           out_valid,
	output logic                           hit,
	output logic [2:0][stl_pkg::CW-1:0]    near,
	output stl_pkg::region_t               region
);

	localparam int F = stl_pkg::FRAC_BITS;

	logic                                 v_s1, v_s2, v_s3, v_s4;
	stl_pkg::pick_t                       pick_s1, pick_s2;
	logic [2:0][stl_pkg::SCW-1:0]         sa_s1, sb_s1;
	logic [2:0][stl_pkg::CW-1:0]          near_s2, near_s3, near_s4;
	stl_pkg::region_t                     region_s3, region_s4;
	logic [2:0][stl_pkg::PW-1:0]          sq_s3;
	logic                                 hit_s4;

	stl_pkg::pick_t                       pick_c;
	logic [2:0][stl_pkg::SCW-1:0]         sa_c, sb_c;
	logic [2:0][stl_pkg::NW-1:0]          sum_c;
	logic [2:0][stl_pkg::CW-1:0]          near_c;
	logic [2:0][stl_pkg::DW-1:0]          diff_c;
	logic [2:0][stl_pkg::PW-1:0]          sq_c;
	logic [stl_pkg::DISTW-1:0]            dist_c;

	always_comb begin
		pick_c = pick;
		if (deg) begin
			pick_c.region = stl_pkg::REG_A;
		end
		for (int i = 0; i < 3; i++) begin
			sa_c[i] = stl_pkg::smul_scale(pick.dir_a[i], {1'b0, t});
			sb_c[i] = stl_pkg::smul_scale(pick.dir_b[i], {1'b0, w});
		end
	end

	// Dropping the fraction of a two's complement product rounds toward minus
	// infinity, which is the rounding wanted here.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = {{(stl_pkg::NW-stl_pkg::CW){pick_s1.base[i][stl_pkg::CW-1]}},
					pick_s1.base[i]}
				+ {sa_s1[i][stl_pkg::SCW-1], sa_s1[i][stl_pkg::SCW-1:F]}
				+ {sb_s1[i][stl_pkg::SCW-1], sb_s1[i][stl_pkg::SCW-1:F]};
			if (pick_s1.region == stl_pkg::REG_A) begin
				near_c[i] = pick_s1.a[i];
			end else if (sum_c[i][stl_pkg::NW-1:stl_pkg::CW-1] == '0
					|| sum_c[i][stl_pkg::NW-1:stl_pkg::CW-1] == '1) begin
				near_c[i] = sum_c[i][stl_pkg::CW-1:0];
			end else begin
				near_c[i] = sum_c[i][stl_pkg::NW-1] ? {1'b1, {(stl_pkg::CW-1){1'b0}}}
					: {1'b0, {(stl_pkg::CW-1){1'b1}}};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = {near_s2[i][stl_pkg::CW-1], near_s2[i]}
				- {pick_s2.p[i][stl_pkg::CW-1], pick_s2.p[i]};
			sq_c[i] = stl_pkg::smul_diff(diff_c[i], diff_c[i]);
		end
		dist_c = {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pick_s1   <= pick_c;
			sa_s1     <= sa_c;
			sb_s1     <= sb_c;
			pick_s2   <= pick_s1;
			near_s2   <= near_c;
			near_s3   <= near_s2;
			region_s3 <= pick_s2.region;
			sq_s3     <= sq_c;
			near_s4   <= near_s3;
			region_s4 <= region_s3;
			hit_s4    <= dist_c <= {{(stl_pkg::DISTW-stl_pkg::R2W){1'b0}}, r2};
		end
	end

	assign out_valid = v_s4;
	assign hit       = hit_s4;
	assign near      = near_s4;
	assign region    = region_s4;

	a_vertex_near: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && (pick_s2.region == stl_pkg::REG_B || pick_s2.region == stl_pkg::REG_C)
		|-> near_s2 == pick_s2.base)
		else $error("vertex region result moved off its vertex");

endmodule
`default_nettype wire

// File: rtl/sphere_triangle_intersect.sv
// Pipeline: 3 dot product stages, 4 cross term and region stages, 18 ratio
// divider stages, 4 output stages. Throughput: one transaction per cycle unless the
// output stalls; the divider retires one quotient bit per stage.
// A stalled output freezes the whole pipeline, nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and sets radius to 1.0.
`default_nettype none
module sphere_triangle_intersect (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// Radius register, unsigned Q15.16, written whenever cfg_we is high.
	input  wire logic          cfg_we,
	input  wire logic [30:0]   cfg_wdata,
	// Input stream.
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// s_tdata from bit 0 up: centre_x, centre_y, centre_z, vert_a_x, vert_a_y,
	// vert_a_z, vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z.
	input  wire logic [383:0]  s_tdata,
	// Result stream.
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// m_tdata from bit 0 up: hit, near_x, near_y, near_z, region, 4 zero bits.
	output logic [103:0]       m_tdata
);

	localparam int CW = stl_pkg::CW;
	localparam int L  = stl_pkg::DIV_LAT;

	logic [stl_pkg::RW-1:0]   radius_q;
	logic [stl_pkg::R2W-1:0]  r2_q;

	// One enable moves every stage; it drops only while a finished result waits.
	logic                     en;

	stl_pkg::tri_t            in_tri;
	logic                     dot_valid;
	stl_pkg::geo_t            geo;
	stl_pkg::dots_t           dots;

	logic                     reg_valid;
	stl_pkg::pick_t           pick;
	logic [stl_pkg::DIVW-1:0] num_a, den_a, num_b, den_b;

	logic [stl_pkg::TW-1:0]   t, w;
	logic                     deg_a, deg_b;

	// The point selection travels beside the dividers.
	logic                     pv_s [L];
	stl_pkg::pick_t           pick_s [L];

	logic                     hit;
	logic [2:0][CW-1:0]       near;
	stl_pkg::region_t         region;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 31'd65536;
			r2_q     <= 62'h1_0000_0000;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			r2_q <= {{(stl_pkg::R2W-stl_pkg::RW){1'b0}}, radius_q}
				* {{(stl_pkg::R2W-stl_pkg::RW){1'b0}}, radius_q};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_tri.p[i] = s_tdata[CW*i +: CW];
			in_tri.a[i] = s_tdata[CW*(3+i) +: CW];
			in_tri.b[i] = s_tdata[CW*(6+i) +: CW];
			in_tri.c[i] = s_tdata[CW*(9+i) +: CW];
		end
	end

	stl_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_tri    (in_tri),
		.out_valid (dot_valid),
		.geo       (geo),
		.dots      (dots)
	);

	stl_region u_region (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dot_valid),
		.geo       (geo),
		.dots      (dots),
		.out_valid (reg_valid),
		.pick      (pick),
		.num_a     (num_a),
		.den_a     (den_a),
		.num_b     (num_b),
		.den_b     (den_b)
	);

	// Divider a yields the edge ratio or the interior v weight, b the interior w.
	stl_div u_div_a (
		.clk (clk),
		.en  (en),
		.num (num_a),
		.den (den_a),
		.t   (t),
		.deg (deg_a)
	);

	stl_div u_div_b (
		.clk (clk),
		.en  (en),
		.num (num_b),
		.den (den_b),
		.t   (w),
		.deg (deg_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < L; k++) begin
				pv_s[k] <= 1'b0;
			end
		end else if (en) begin
			pv_s[0] <= reg_valid;
			for (int k = 1; k < L; k++) begin
				pv_s[k] <= pv_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pick_s[0] <= pick;
			for (int k = 1; k < L; k++) begin
				pick_s[k] <= pick_s[k-1];
			end
		end
	end

	// A zero divisor on either lane falls back to vertex a.
	stl_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pv_s[L-1]),
		.pick      (pick_s[L-1]),
		.t         (t),
		.w         (w),
		.deg       (deg_a || deg_b),
		.r2        (r2_q),
		.out_valid (m_tvalid),
		.hit       (hit),
		.near      (near),
		.region    (region)
	);

	assign m_tdata = {4'b0000, region, near[2], near[1], near[0], hit};

endmodule
`default_nettype wire

// File: sim/sphere_triangle_intersect_tb.sv
`timescale 1ns / 1ps

module sphere_triangle_intersect_tb;

	// Wide enough for every dot product, cross term and squared distance.
	typedef logic signed [191:0] wide_t;

	// One expected result transaction.
	typedef struct {
		logic             hit;
		logic [31:0]      near_x;
		logic [31:0]      near_y;
		logic [31:0]      near_z;
		stl_pkg::region_t region;
	} contact_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;    // comfortably above the pipeline depth
	localparam longint ONE_Q      = longint'(1) << stl_pkg::FRAC_BITS;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [30:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [383:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;

	contact_t     contact_q[$];
	logic [30:0]  radius_now;
	bit           idle_on;
	bit           failed;
	int           hold_cycles;
	int           quiet_cycles;

	sphere_triangle_intersect i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Coordinate i of an input transaction: 0..2 centre, 3..5 a, 6..8 b, 9..11 c.
	function automatic longint coord(logic [383:0] v, int i);
		return longint'($signed(v[32*i +: 32]));
	endfunction

	function automatic wide_t dot3(longint ux, longint uy, longint uz,
			longint vx, longint vy, longint vz);
		return wide_t'(ux) * wide_t'(vx) + wide_t'(uy) * wide_t'(vy)
			+ wide_t'(uz) * wide_t'(vz);
	endfunction

	// Quotient truncated to the fraction width and clamped to [0, 1].
	// Returns 0 when the divisor is zero.
	function automatic bit bary_ratio(wide_t num, wide_t den, output longint t);
		t = 0;
		if (den == 0)
			return 1'b0;
		if (num == 0 || ((num < 0) != (den < 0)))
			return 1'b1;
		if (num < 0) begin
			num = -num;
			den = -den;
		end
		if (num >= den)
			t = ONE_Q;
		else
			t = longint'((num <<< stl_pkg::FRAC_BITS) / den);
		return 1'b1;
	endfunction

	// Direction times ratio, floored after the fraction bits are dropped.
	function automatic longint scaled(longint d, longint t);
		return (d * t) >>> stl_pkg::FRAC_BITS;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Closest point on the triangle, its Voronoi region and the hit flag.
	function automatic contact_t closest_contact(logic [383:0] v, logic [30:0] rad);
		longint p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
		longint near[3];
		longint t, w;
		wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56, dist_sq, r2, dd;
		stl_pkg::region_t rg;
		contact_t res;
		bit ok;
		for (int i = 0; i < 3; i++) begin
			p[i]  = coord(v, i);
			a[i]  = coord(v, 3 + i);
			b[i]  = coord(v, 6 + i);
			c[i]  = coord(v, 9 + i);
			ab[i] = b[i] - a[i];
			ac[i] = c[i] - a[i];
			bc[i] = c[i] - b[i];
			ap[i] = p[i] - a[i];
			bp[i] = p[i] - b[i];
			cp[i] = p[i] - c[i];
			near[i] = a[i];
		end
		d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
		d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
		d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
		d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
		d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
		d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
		vc = d1 * d4 - d3 * d2;
		vb = d5 * d2 - d1 * d6;
		va = d3 * d6 - d5 * d4;
		e43 = d4 - d3;
		e56 = d5 - d6;
		t = 0;
		w = 0;

		if (d1 <= 0 && d2 <= 0) begin
			rg = stl_pkg::REG_A;
		end else if (d3 >= 0 && d4 <= d3) begin
			rg = stl_pkg::REG_B;
			for (int i = 0; i < 3; i++) near[i] = b[i];
		end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
			rg = stl_pkg::REG_AB;
			if (bary_ratio(d1, d1 - d3, t))
				for (int i = 0; i < 3; i++) near[i] = a[i] + scaled(ab[i], t);
			else
				rg = stl_pkg::REG_A;
		end else if (d6 >= 0 && d5 <= d6) begin
			rg = stl_pkg::REG_C;
			for (int i = 0; i < 3; i++) near[i] = c[i];
		end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
			rg = stl_pkg::REG_AC;
			if (bary_ratio(d2, d2 - d6, t))
				for (int i = 0; i < 3; i++) near[i] = a[i] + scaled(ac[i], t);
			else
				rg = stl_pkg::REG_A;
		end else if (va <= 0 && e43 >= 0 && e56 >= 0) begin
			rg = stl_pkg::REG_BC;
			if (bary_ratio(e43, e43 + e56, t))
				for (int i = 0; i < 3; i++) near[i] = b[i] + scaled(bc[i], t);
			else
				rg = stl_pkg::REG_A;
		end else begin
			rg = stl_pkg::REG_IN;
			ok = bary_ratio(vb, va + vb + vc, t);
			if (ok)
				ok = bary_ratio(vc, va + vb + vc, w);
			if (ok)
				for (int i = 0; i < 3; i++)
					near[i] = sat32(a[i] + scaled(ab[i], t) + scaled(ac[i], w));
			else
				rg = stl_pkg::REG_A;
		end
		// A degenerate triangle falls back to vertex a.
		if (rg == stl_pkg::REG_A)
			for (int i = 0; i < 3; i++) near[i] = a[i];

		dist_sq = 0;
		for (int i = 0; i < 3; i++) begin
			dd = wide_t'(near[i] - p[i]);
			dist_sq = dist_sq + dd * dd;
		end
		r2 = wide_t'({1'b0, rad}) * wide_t'({1'b0, rad});

		res.hit    = (dist_sq <= r2);
		res.near_x = near[0][31:0];
		res.near_y = near[1][31:0];
		res.near_z = near[2][31:0];
		res.region = rg;
		return res;
	endfunction

	// Drives one input transaction and records its expected result once
	// the handshake completes. s_tvalid stays high into the next call.
	task automatic send_triangle(logic [383:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		contact_q.push_back(closest_contact(v, radius_now));
	endtask

	task automatic pack_send(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
			logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
		send_triangle({cz, cy, cx, bz, by, bx, az, ay, ax, pz, py, px});
	endtask

	task automatic end_stream();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every result is back and the pipeline has run dry.
	task automatic drain_pipeline();
		end_stream();
		wait (contact_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_radius(logic [30:0] rad);
		drain_pipeline();
		cfg_we    <= 1'b1;
		cfg_wdata <= rad;
		@(posedge clk);
		cfg_we    <= 1'b0;
		radius_now = rad;
	endtask

	// Small coordinates keep results near the radius, so hits go both ways.
	function automatic logic [31:0] rand_coord(bit full);
		if (full)
			return $urandom;
		return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
	endfunction

	task automatic send_random_triangle();
		logic [31:0] f[12];
		bit full;
		full = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < 12; i++) f[i] = rand_coord(full);
		case ($urandom_range(0, 9))
			0: begin
				// Vertex c on top of vertex a.
				f[9] = f[3]; f[10] = f[4]; f[11] = f[5];
			end
			1: begin
				// Fully collapsed triangle.
				f[6] = f[3]; f[7] = f[4]; f[8] = f[5];
				f[9] = f[3]; f[10] = f[4]; f[11] = f[5];
			end
			default: ;
		endcase
		pack_send(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]);
	endtask

	// A centre in each Voronoi region of a right triangle in the z = 0 plane, two in the interior.
	task automatic test_regions();
		logic [31:0] u10;
		u10 = 32'h000A_0000;
		pack_send(-32'sh10000, -32'sh10000, 0, 0, 0, 0, u10, 0, 0, 0, u10, 0);
		pack_send(32'h000B_0000, -32'sh10000, 0, 0, 0, 0, u10, 0, 0, 0, u10, 0);
		pack_send(32'h0005_0000, -32'sh8000, 0, 0, 0, 0, u10, 0, 0, 0, u10, 0);
		pack_send(-32'sh10000, 32'h000B_0000, 0, 0, 0, 0, u10, 0, 0, 0, u10, 0);
		pack_send(-32'sh8000, 32'h0005_0000, 0, 0, 0, 0, u10, 0, 0, 0, u10, 0);
		pack_send(32'h0006_0000, 32'h0006_0000, 32'h0000_4000, 0, 0, 0, u10, 0, 0,
			0, u10, 0);
		pack_send(32'h0002_0000, 32'h0003_0000, 32'h0000_8000, 0, 0, 0, u10, 0, 0,
			0, u10, 0);
		pack_send(32'h0002_5555, 32'h0003_1234, 32'h0003_0000, 0, 0, 0, u10, 0, 0,
			0, u10, 0);
		// Degenerate triangles: a single point, then three collinear vertices.
		pack_send(32'h0001_0000, 32'h0002_0000, 0, 32'h0003_0000, 0, 0,
			32'h0003_0000, 0, 0, 32'h0003_0000, 0, 0);
		pack_send(32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0, u10, 0, 0,
			32'h0005_0000, 0, 0);
		drain_pipeline();
	endtask

	// Coordinates at both ends of the signed range.
	task automatic test_extremes();
		logic [31:0] lo, hi;
		lo = 32'h8000_0000;
		hi = 32'h7FFF_FFFF;
		pack_send(lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo);
		pack_send(hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi);
		pack_send(hi, hi, hi, lo, lo, lo, hi, lo, lo, lo, hi, lo);
		pack_send(lo, lo, lo, hi, hi, hi, lo, hi, hi, hi, lo, hi);
		pack_send(0, 0, hi, lo, lo, 0, hi, lo, 0, lo, hi, 0);
		pack_send(lo, hi, lo, hi, lo, hi, lo, hi, lo, hi, lo, hi);
		pack_send(32'hFFFF_FFFF, 0, 32'h1, lo, lo, lo, hi, hi, lo, lo, hi, hi);
		pack_send(hi, hi, 0, lo, lo, 0, hi, lo, 0, lo, hi, 0);
		drain_pipeline();
	endtask

	task automatic test_radius_limits();
		set_radius(31'd0);
		for (int i = 0; i < 20; i++) send_random_triangle();
		// Centre exactly on vertex a still hits with a zero radius.
		pack_send(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0005_0000, 0, 0,
			0, 32'h0005_0000, 0);
		set_radius(31'h7FFF_FFFF);
		for (int i = 0; i < 20; i++) send_random_triangle();
	endtask

	task automatic test_random_stream(int n);
		set_radius(31'($urandom_range(0, 32'h0010_0000)));
		for (int i = 0; i < n; i++) send_random_triangle();
	endtask

	// The receiver holds off long enough for the pipeline to fill and stall
	// the input, while the sender keeps offering transactions.
	task automatic test_backpressure();
		set_radius(31'($urandom));
		hold_cycles = 300;
		for (int i = 0; i < 100; i++) send_random_triangle();
	endtask

	// The sender pauses until every outstanding result has come back.
	task automatic test_sender_pause();
		for (int i = 0; i < 40; i++) send_random_triangle();
		end_stream();
		wait (contact_q.size() == 0);
		for (int i = 0; i < 40; i++) send_random_triangle();
	endtask

	task automatic test_full_rate();
		set_radius(31'($urandom_range(0, 32'h0008_0000)));
		idle_on = 1'b0;
		for (int i = 0; i < 150; i++) send_random_triangle();
	endtask

	// Receiver ready: long hold requested by a test, else random bursts.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Every accepted result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		contact_t exp_c;
		if (m_tvalid && m_tready) begin
			if (contact_q.size() == 0) begin
				$error("result transaction with no expectation waiting");
				failed = 1'b1;
			end else begin
				exp_c = contact_q.pop_front();
				if (m_tdata[0] !== exp_c.hit) begin
					$error("hit expected %0d got %0d", exp_c.hit, m_tdata[0]);
					failed = 1'b1;
				end
				if (m_tdata[32:1] !== exp_c.near_x) begin
					$error("near_x expected %h got %h", exp_c.near_x, m_tdata[32:1]);
					failed = 1'b1;
				end
				if (m_tdata[64:33] !== exp_c.near_y) begin
					$error("near_y expected %h got %h", exp_c.near_y, m_tdata[64:33]);
					failed = 1'b1;
				end
				if (m_tdata[96:65] !== exp_c.near_z) begin
					$error("near_z expected %h got %h", exp_c.near_z, m_tdata[96:65]);
					failed = 1'b1;
				end
				if (m_tdata[99:97] !== exp_c.region) begin
					$error("region expected %0d got %0d", exp_c.region, m_tdata[99:97]);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog: counts cycles with work outstanding but no transaction on
	// either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else if (s_tvalid || contact_q.size() != 0)
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("sphere_triangle_intersect test failed");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		radius_now  = 31'd65536;
		idle_on     = 1'b1;
		failed      = 1'b0;
		hold_cycles = 0;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_regions();
		test_extremes();
		test_radius_limits();
		test_random_stream(200);
		test_backpressure();
		test_random_stream(200);
		test_sender_pause();
		test_random_stream(100);
		test_full_rate();

		drain_pipeline();
		if (!failed) begin
			$display("sphere_triangle_intersect test passed");
		end else begin
			$display("sphere_triangle_intersect test failed");
		end
		$finish;
	end

endmodule
